// File: hdl/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types, constants and helpers of the RFID frame check and whitelist.
// ----------------------------------------------------------------------------
package rfc_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;   // power of two, at least 2

  localparam int TAG_W    = 40;
  localparam int SHIFT_W  = 48;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 16;

  localparam logic [7:0]       STX_BYTE     = 8'h02;
  localparam logic [3:0]       FRAME_DIGITS = 4'd12;
  localparam logic [TAG_W-1:0] FIRST_TAG    = 40'h67_0099_9FF2;
  localparam logic [7:0]       DIGIT_BASE   = 8'd48;  // '0'
  localparam logic [7:0]       ALPHA_BASE   = 8'd55;  // 'A' - 10
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_DENIED    = 3'd1,
    ST_ADDED     = 3'd2,
    ST_FULL      = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_BAD_SUM   = 3'd6,
    ST_BAD_CHAR  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    ACT_CHECK = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_DEL   = 2'd2,
    ACT_SPARE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    JK_ACT      = 2'd0,
    JK_BAD_SUM  = 2'd1,
    JK_BAD_CHAR = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [TAG_W-1:0] tag;
  } job_t;

  typedef enum logic [1:0] {
    BS_IDLE = 2'd0,
    BS_SCAN = 2'd1,
    BS_FIN  = 2'd2
  } back_state_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [7:0] d;
    d = 8'd0;
    if (b inside {[8'h30:8'h39]}) begin
      d = b - DIGIT_BASE;
      return {1'b1, d[3:0]};
    end
    if (b inside {[8'h41:8'h46]}) begin
      d = b - ALPHA_BASE;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic [7:0] tag_xor(input logic [TAG_W-1:0] t);
    return t[39:32] ^ t[31:24] ^ t[23:16] ^ t[15:8] ^ t[7:0];
  endfunction

endpackage

// File: hdl/rfid_frame_check_and_tag_whitelist_top.sv
// ----------------------------------------------------------------------------
// rfid_frame_check_and_tag_whitelist_top
// RFID reader frame checker with a whitelist of tag numbers.
// ----------------------------------------------------------------------------
// Reader bytes enter one per cycle at in_rx_byte while in_stall is low. STX
// opens a frame of ten tag digits and two checksum digits; the parser decodes
// every byte combinationally and hands each finished or aborted frame to a
// two-entry job queue, so bytes keep flowing while the table engine is busy
// (in_stall rises only when that queue is full). For a tag job the table
// engine takes the job, sweeps the whitelist RAM one entry a cycle through
// its registered read port and closes the sweep, then applies the action and
// loads the result word; checksum and bad character jobs skip the sweep.
// Results wait in an output register while out_stall is high. The whitelist
// holds only the factory tag after reset; no clearing pass is needed, entry
// validity lives in flip-flops. Write cfg_tag_action only while no frame is
// in flight.
module rfid_frame_check_and_tag_whitelist_top #(
  parameter int TABLE_DEPTH = rfc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rfc_pkg::TAG_W-1:0]     out_tag_id,
  output logic [rfc_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_lock_open,
  output logic [rfc_pkg::COUNT_W-1:0]   out_failed_attempts,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_tag_action
);
  import rfc_pkg::*;

  action_t action_r;
  job_t    push_job, q_head;
  logic    push, q_pop, q_empty, q_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      action_r <= ACT_CHECK;
    end else if (cfg_valid && cfg_ready) begin
      action_r <= action_t'(cfg_tag_action);
    end
  end

  rfc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  rfc_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  rfc_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .action              (action_r),
    .q_head              (q_head),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_tag_id          (out_tag_id),
    .out_status          (out_status),
    .out_lock_open       (out_lock_open),
    .out_failed_attempts (out_failed_attempts)
  );

  // lock opens exactly on a granted word
  a_lock_granted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lock_open == (out_status == ST_GRANTED)))
    else $error("lock_open disagrees with status");

  // aborted frames never leak partial digits
  a_bad_char_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_BAD_CHAR) |-> (out_tag_id == '0))
    else $error("bad character word carries a tag");

  // a denial always shows a counted failure
  a_denied_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_DENIED) |-> (out_failed_attempts != '0))
    else $error("denied word with zero failure count");

  // no byte is accepted while the job queue is full
  a_queue_guard: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !(in_valid && !in_stall))
    else $error("byte accepted with job queue full");

endmodule

// File: hdl/rfc_ram.sv
// ----------------------------------------------------------------------------
// rfc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/rfc_front.sv
// ----------------------------------------------------------------------------
// rfc_front
// Frame parser: gathers hex digits after STX, checks the XOR sum and queues
// one job per finished or aborted frame.
// ----------------------------------------------------------------------------
module rfc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_rx_byte,
  input  logic          q_full,
  output logic          push,
  output rfc_pkg::job_t push_job
);
  import rfc_pkg::*;

  logic               in_frame_r, in_frame_nxt;
  logic [3:0]         nib_cnt_r, nib_cnt_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;

  logic               accept;
  logic [4:0]         hex;
  logic [SHIFT_W-1:0] shift_app;
  logic [TAG_W-1:0]   tag_w;

  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;
  assign hex       = hex_decode(in_rx_byte);
  assign shift_app = {shift_r[SHIFT_W-5:0], hex[3:0]};
  assign tag_w     = shift_app[SHIFT_W-1:8];

  always_comb begin
    in_frame_nxt  = in_frame_r;
    nib_cnt_nxt   = nib_cnt_r;
    shift_nxt     = shift_r;
    push          = 1'b0;
    push_job.kind = JK_ACT;
    push_job.tag  = tag_w;
    if (accept) begin
      if (in_rx_byte == STX_BYTE) begin
        in_frame_nxt = 1'b1;
        nib_cnt_nxt  = 4'd0;
        shift_nxt    = '0;
      end else if (in_frame_r) begin
        if (!hex[4]) begin
          in_frame_nxt  = 1'b0;
          nib_cnt_nxt   = 4'd0;
          shift_nxt     = '0;
          push          = 1'b1;
          push_job.kind = JK_BAD_CHAR;
          push_job.tag  = '0;
        end else begin
          shift_nxt = shift_app;
          if (nib_cnt_r == FRAME_DIGITS - 4'd1) begin
            in_frame_nxt  = 1'b0;
            nib_cnt_nxt   = 4'd0;
            push          = 1'b1;
            push_job.kind = (tag_xor(tag_w) == shift_app[7:0]) ? JK_ACT : JK_BAD_SUM;
          end else begin
            nib_cnt_nxt = nib_cnt_r + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      nib_cnt_r  <= 4'd0;
      shift_r    <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      nib_cnt_r  <= nib_cnt_nxt;
      shift_r    <= shift_nxt;
    end
  end

endmodule

// File: hdl/rfc_fifo.sv
// ----------------------------------------------------------------------------
// rfc_fifo
// Short job queue between the frame parser and the table engine.
// ----------------------------------------------------------------------------
module rfc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rfc_pkg::job_t push_job,
  input  logic          pop,
  output rfc_pkg::job_t head,
  output logic          empty,
  output logic          full
);
  import rfc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign empty   = (count_r == CW'(0));
  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: hdl/rfc_back.sv
// ----------------------------------------------------------------------------
// rfc_back
// Table engine: scans the whitelist one entry a cycle for tag jobs, applies
// the action and holds the result word in the output register.
// ----------------------------------------------------------------------------
module rfc_back #(
  parameter int TABLE_DEPTH = rfc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rfc_pkg::action_t              action,
  input  rfc_pkg::job_t                 q_head,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rfc_pkg::TAG_W-1:0]     out_tag_id,
  output logic [rfc_pkg::STATUS_W-1:0]  out_status,
  output logic                          out_lock_open,
  output logic [rfc_pkg::COUNT_W-1:0]   out_failed_attempts
);
  import rfc_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  back_state_t        state_r, state_nxt;
  job_t               job_r, job_nxt;
  logic [CNT_W-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic               free_r, free_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic               init0_r, init0_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [COUNT_W-1:0] denied_r, denied_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [TAG_W-1:0]   out_tag_r;
  status_t            out_status_r;
  logic               out_lock_r;
  logic [COUNT_W-1:0] out_fail_r;

  logic [TAG_W-1:0]   ram_rdata, entry_w;
  logic               ram_we;
  logic               cmp_hit, cmp_free, scan_done, fire;
  status_t            fin_status;
  logic               fin_lock;

  rfc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (job_r.tag),
    .raddr (scan_cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // entry 0 holds the factory tag until it is first overwritten
  assign entry_w   = (rd_idx_r == '0 && init0_r) ? FIRST_TAG : ram_rdata;
  assign cmp_hit   = rd_pend_r && valid_r[rd_idx_r] && (entry_w == job_r.tag);
  assign cmp_free  = rd_pend_r && !valid_r[rd_idx_r];
  assign scan_done = (scan_cnt_r == CNT_W'(TABLE_DEPTH)) && !rd_pend_r;
  assign fire      = (state_r == BS_FIN) && (!out_valid_r || !out_stall);
  assign q_pop     = (state_r == BS_IDLE) && !q_empty;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_head.kind == JK_ACT) ? BS_SCAN : BS_FIN;
        end
      end
      BS_SCAN: begin
        if (scan_done) begin
          state_nxt = BS_FIN;
        end
      end
      BS_FIN: begin
        if (fire) begin
          state_nxt = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  // result of a finished job
  always_comb begin
    fin_status = ST_BAD_CHAR;
    fin_lock   = 1'b0;
    case (job_r.kind)
      JK_BAD_CHAR: fin_status = ST_BAD_CHAR;
      JK_BAD_SUM:  fin_status = ST_BAD_SUM;
      JK_ACT: begin
        case (action)
          ACT_ADD: fin_status = (hit_r || free_r) ? ST_ADDED : ST_FULL;
          ACT_DEL: fin_status = hit_r ? ST_REMOVED : ST_NOT_FOUND;
          default: begin
            fin_status = hit_r ? ST_GRANTED : ST_DENIED;
            fin_lock   = hit_r;
          end
        endcase
      end
      default: fin_status = ST_BAD_CHAR;
    endcase
  end

  // datapath and outputs
  always_comb begin
    job_nxt       = job_r;
    scan_cnt_nxt  = scan_cnt_r;
    rd_pend_nxt   = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    init0_nxt     = init0_r;
    valid_nxt     = valid_r;
    denied_nxt    = denied_r;
    ram_we        = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      BS_IDLE: begin
        if (q_pop) begin
          job_nxt      = q_head;
          scan_cnt_nxt = '0;
          hit_nxt      = 1'b0;
          free_nxt     = 1'b0;
        end
      end
      BS_SCAN: begin
        if (scan_cnt_r != CNT_W'(TABLE_DEPTH)) begin
          rd_pend_nxt  = 1'b1;
          rd_idx_nxt   = scan_cnt_r[IDX_W-1:0];
          scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
        end
        // first hit and first free slot win
        if (cmp_hit && !hit_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = rd_idx_r;
        end
        if (cmp_free && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = rd_idx_r;
        end
      end
      BS_FIN: begin
        if (fire) begin
          out_valid_nxt = 1'b1;
          if (job_r.kind == JK_ACT) begin
            case (action)
              ACT_ADD: begin
                if (!hit_r && free_r) begin
                  ram_we                = 1'b1;
                  valid_nxt[free_idx_r] = 1'b1;
                  if (free_idx_r == '0) begin
                    init0_nxt = 1'b0;
                  end
                end
              end
              ACT_DEL: begin
                if (hit_r) begin
                  valid_nxt[hit_idx_r] = 1'b0;
                end
              end
              default: begin
                if (!hit_r && denied_r != COUNT_MAX) begin
                  denied_nxt = denied_r + COUNT_W'(1);
                end
              end
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      rd_pend_r   <= 1'b0;
      init0_r     <= 1'b1;
      valid_r     <= TABLE_DEPTH'(1);
      denied_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      init0_r     <= init0_nxt;
      valid_r     <= valid_nxt;
      denied_r    <= denied_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    rd_idx_r   <= rd_idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    if (fire) begin
      out_tag_r    <= job_r.tag;
      out_status_r <= fin_status;
      out_lock_r   <= fin_lock;
      out_fail_r   <= denied_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_tag_id          = out_tag_r;
  assign out_status          = out_status_r;
  assign out_lock_open       = out_lock_r;
  assign out_failed_attempts = out_fail_r;

endmodule
